### hw/rtl/dcp_pkg.sv
// shared types and constants for the dominance coefficient block
// no dependencies
package dcp_pkg;

  localparam int IDX_W   = 10;
  localparam int SLOT_W  = 15;
  localparam int VAL_W   = 18;
  localparam int COEF_W  = 36;
  localparam int POS_W   = 16;
  localparam int PAR_W   = 22;

  localparam int DEF_MAX_INDIVIDUALS = 1024;
  localparam int DEF_MAX_ENTRIES     = 16384;

  typedef enum logic [1:0] {
    OP_LOAD_PARENT = 2'd0,
    OP_LOAD_COLUMN = 2'd1,
    OP_LOAD_ENTRY  = 2'd2,
    OP_QUERY       = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PAR, ST_COL, ST_SE, ST_SRCH, ST_FIN, ST_MUL0, ST_MUL1, ST_DONE
  } state_t;

  // load request towards the stores
  typedef struct packed {
    logic                  par_we;
    logic                  col_we;
    logic                  ent_we;
    logic [SLOT_W-1:0]     slot;
    logic [PAR_W-1:0]      par_data;
    logic [SLOT_W-1:0]     col_data;
    logic [IDX_W-1:0]      row_data;
    logic [VAL_W-1:0]      val_data;
  } wr_req_t;

  // sequencer status
  typedef struct packed {
    logic   busy;
    state_t state;
  } seq_stat_t;

endpackage

### hw/rtl/dcp_store.sv
// pedigree, column start and matrix entry memories, registered reads
// depends on dcp_pkg
module dcp_store
  import dcp_pkg::*;
#(
  parameter int MAX_INDIVIDUALS = DEF_MAX_INDIVIDUALS,
  parameter int MAX_ENTRIES     = DEF_MAX_ENTRIES,
  localparam int PAW = $clog2(MAX_INDIVIDUALS),
  localparam int CAW = $clog2(MAX_INDIVIDUALS + 1),
  localparam int EAW = $clog2(MAX_ENTRIES)
) (
  input  logic             clk,
  input  wr_req_t          wr,
  input  logic [PAW-1:0]   par_addr_a,
  input  logic [PAW-1:0]   par_addr_b,
  output logic [PAR_W-1:0] par_rd_a,
  output logic [PAR_W-1:0] par_rd_b,
  input  logic [CAW-1:0]   col_addr_a,
  input  logic [CAW-1:0]   col_addr_b,
  output logic [SLOT_W-1:0] col_rd_a,
  output logic [SLOT_W-1:0] col_rd_b,
  input  logic [EAW-1:0]   ent_addr,
  output logic [IDX_W-1:0] row_rd,
  output logic [VAL_W-1:0] val_rd
);

  logic [PAR_W-1:0]  parent_mem [MAX_INDIVIDUALS];
  logic [SLOT_W-1:0] col_mem    [MAX_INDIVIDUALS + 1];
  logic [IDX_W-1:0]  row_mem    [MAX_ENTRIES];
  logic [VAL_W-1:0]  val_mem    [MAX_ENTRIES];

  logic slot_par_ok, slot_col_ok, slot_ent_ok;

  // loads beyond a store are dropped
  assign slot_par_ok = 32'(wr.slot) < MAX_INDIVIDUALS;
  assign slot_col_ok = 32'(wr.slot) < MAX_INDIVIDUALS + 1;
  assign slot_ent_ok = 32'(wr.slot) < MAX_ENTRIES;

  // pedigree table
  always_ff @(posedge clk) begin
    if (wr.par_we && slot_par_ok) begin
      parent_mem[PAW'(wr.slot)] <= wr.par_data;
    end
    par_rd_a <= parent_mem[par_addr_a];
    par_rd_b <= parent_mem[par_addr_b];
  end

  // column starts
  always_ff @(posedge clk) begin
    if (wr.col_we && slot_col_ok) begin
      col_mem[CAW'(wr.slot)] <= wr.col_data;
    end
    col_rd_a <= col_mem[col_addr_a];
    col_rd_b <= col_mem[col_addr_b];
  end

  // row indices and values share one address
  always_ff @(posedge clk) begin
    if (wr.ent_we && slot_ent_ok) begin
      row_mem[EAW'(wr.slot)] <= wr.row_data;
      val_mem[EAW'(wr.slot)] <= wr.val_data;
    end
    row_rd <= row_mem[ent_addr];
    val_rd <= val_mem[ent_addr];
  end

endmodule

### hw/rtl/dcp_seq.sv
// query sequencer: parent lookup, four binary searches, products, result register
// depends on dcp_pkg
module dcp_seq
  import dcp_pkg::*;
#(
  parameter int MAX_INDIVIDUALS = DEF_MAX_INDIVIDUALS,
  parameter int MAX_ENTRIES     = DEF_MAX_ENTRIES,
  localparam int PAW = $clog2(MAX_INDIVIDUALS),
  localparam int CAW = $clog2(MAX_INDIVIDUALS + 1),
  localparam int EAW = $clog2(MAX_ENTRIES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IDX_W-1:0]  first_individual,
  input  logic [IDX_W-1:0]  second_individual,
  input  logic              last_pair,
  output logic [PAW-1:0]    par_addr_a,
  output logic [PAW-1:0]    par_addr_b,
  input  logic [PAR_W-1:0]  par_rd_a,
  input  logic [PAR_W-1:0]  par_rd_b,
  output logic [CAW-1:0]    col_addr_a,
  output logic [CAW-1:0]    col_addr_b,
  input  logic [SLOT_W-1:0] col_rd_a,
  input  logic [SLOT_W-1:0] col_rd_b,
  output logic [EAW-1:0]    ent_addr,
  input  logic [IDX_W-1:0]  row_rd,
  input  logic [VAL_W-1:0]  val_rd,
  output seq_stat_t         stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COEF_W-1:0] coefficient,
  output logic              written,
  output logic              batch_end
);

  state_t state, state_next;

  logic [IDX_W-1:0]  ind_a, ind_b;
  logic              last_q;
  logic [IDX_W-1:0]  kd, ks, jd, js;
  logic [1:0]        li;
  logic [IDX_W-1:0]  row_q;
  logic [POS_W-1:0]  m, probe;
  logic [SLOT_W-1:0] n;
  logic [VAL_W-1:0]  vals [4];
  logic [COEF_W-1:0] p0, p1;

  // combinational datapath
  logic              qualify;
  logic [IDX_W-1:0]  pa, pb, col_c, row_c;
  logic              col_ok;
  logic              se_empty;
  logic [SLOT_W-1:0] se_n;
  logic              probe_ok, lt;
  logic [POS_W-1:0]  m_n;
  logic [SLOT_W-1:0] n_n;
  logic              hit;
  logic [COEF_W:0]   sum;
  logic [COEF_W-1:0] sum_sat;
  logic              out_free;

  // pair qualification from the pedigree read
  assign qualify = (32'(ind_a) < MAX_INDIVIDUALS) && (32'(ind_b) < MAX_INDIVIDUALS)
                   && (ind_a != ind_b) && par_rd_a[10] && par_rd_a[21]
                   && par_rd_b[10] && par_rd_b[21];

  // parent pair for the current lookup: mm, ff, mf, fm
  always_comb begin
    unique case (li)
      2'd0:    begin pa = kd; pb = jd; end
      2'd1:    begin pa = ks; pb = js; end
      2'd2:    begin pa = kd; pb = js; end
      default: begin pa = ks; pb = jd; end
    endcase
    col_c = (pa > pb) ? pa : pb;
    row_c = (pa > pb) ? pb : pa;
  end
  assign col_ok = 32'(col_c) < MAX_INDIVIDUALS;

  // column bounds
  assign se_empty = col_rd_b <= col_rd_a;
  assign se_n     = col_rd_b - col_rd_a - SLOT_W'(1);

  // one probe step of the lower-bound search
  assign probe_ok = 32'(probe) < MAX_ENTRIES;
  assign lt       = probe_ok && (row_rd < row_q);
  always_comb begin
    if (lt) begin
      m_n = probe + POS_W'(1);
      n_n = n - (n >> 1) - SLOT_W'(1);
    end else begin
      m_n = m;
      n_n = n >> 1;
    end
  end
  assign hit = probe_ok && (row_rd == row_q);

  // final sum with saturation
  assign sum      = {1'b0, p0} + {1'b0, p1};
  assign sum_sat  = sum[COEF_W] ? {COEF_W{1'b1}} : sum[COEF_W-1:0];
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_PAR;
      ST_PAR:  state_next = qualify ? ST_COL : ST_DONE;
      ST_COL: begin
        if (col_ok) state_next = ST_SE;
        else if (li == 2'd3) state_next = ST_MUL0;
      end
      ST_SE: begin
        if (se_empty) state_next = (li == 2'd3) ? ST_MUL0 : ST_COL;
        else if (se_n != '0) state_next = ST_SRCH;
        else state_next = ST_FIN;
      end
      ST_SRCH: if (n_n == '0) state_next = ST_FIN;
      ST_FIN:  state_next = (li == 2'd3) ? ST_MUL0 : ST_COL;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory read addresses
  logic [POS_W-1:0] ent_pos;
  always_comb begin
    par_addr_a = PAW'(first_individual);
    par_addr_b = PAW'(second_individual);
    col_addr_a = CAW'(col_c);
    col_addr_b = CAW'({1'b0, col_c} + (IDX_W + 1)'(1));
    ent_pos    = probe;
    unique case (state)
      ST_SE:   ent_pos = (se_n != '0) ? POS_W'(col_rd_a) + POS_W'(se_n >> 1)
                                      : POS_W'(col_rd_a);
      ST_SRCH: ent_pos = (n_n != '0) ? m_n + POS_W'(n_n >> 1) : m_n;
      default: ent_pos = probe;
    endcase
    ent_addr = EAW'(ent_pos);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      li        <= 2'd0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_PAR) begin
        li <= 2'd0;
      end else if ((state == ST_COL && !col_ok) || (state == ST_SE && se_empty)
                   || state == ST_FIN) begin
        li <= li + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      ind_a  <= first_individual;
      ind_b  <= second_individual;
      last_q <= last_pair;
    end
    if (state == ST_PAR) begin
      kd <= par_rd_a[9:0];
      ks <= par_rd_a[20:11];
      jd <= par_rd_b[9:0];
      js <= par_rd_b[20:11];
      p0 <= '0;
      p1 <= '0;
    end
    if (state == ST_COL) begin
      row_q <= row_c;
      if (!col_ok) vals[li] <= '0;
    end
    if (state == ST_SE) begin
      m     <= POS_W'(col_rd_a);
      n     <= se_n;
      probe <= ent_pos;
      if (se_empty) vals[li] <= '0;
    end
    if (state == ST_SRCH) begin
      m     <= m_n;
      n     <= n_n;
      probe <= ent_pos;
    end
    if (state == ST_FIN) begin
      vals[li] <= hit ? val_rd : '0;
    end
    if (state == ST_MUL0) p0 <= vals[0] * vals[1];
    if (state == ST_MUL1) p1 <= vals[2] * vals[3];
    if (state == ST_DONE && out_free) begin
      coefficient <= sum_sat;
      written     <= sum_sat != '0;
      batch_end   <= last_q;
    end
  end

  assign stat.busy  = state != ST_IDLE;
  assign stat.state = state;

endmodule

### hw/rtl/dominance_coefficient_pairs_top.sv
// top level of the dominance coefficient block: stores plus query sequencer
// depends on dcp_pkg, dcp_store, dcp_seq
//
//  channel | direction | handshake          | payload
//  in      | request in | in_valid/in_stall  | opcode, slot, pedigree, column, entry, query
//  out     | result out | out_valid/out_stall| coefficient, written, batch_end
//
// a query does the parent lookup, then for each of four parent pairs a column read, a
// bounds step, the search probes and a final step, then two products; probes is the
// number of search steps, about log2 of the column length, one a cycle on the entry memory
// port. an empty column skips the search; a pair that does not qualify goes to its result.
// rst is synchronous and clears control only; the memories hold nothing until loaded.
// the result register frees the sequencer: a new request is taken while a result waits,
// and only a second finished result waits on out_stall.
module dominance_coefficient_pairs_top
  import dcp_pkg::*;
#(
  parameter int MAX_INDIVIDUALS = DEF_MAX_INDIVIDUALS,
  parameter int MAX_ENTRIES     = DEF_MAX_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [SLOT_W-1:0] slot,
  input  logic [IDX_W-1:0]  dam_index,
  input  logic              dam_known,
  input  logic [IDX_W-1:0]  sire_index,
  input  logic              sire_known,
  input  logic [SLOT_W-1:0] column_start,
  input  logic [IDX_W-1:0]  entry_row,
  input  logic [VAL_W-1:0]  entry_value,
  input  logic [IDX_W-1:0]  first_individual,
  input  logic [IDX_W-1:0]  second_individual,
  input  logic              last_pair,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COEF_W-1:0] coefficient,
  output logic              written,
  output logic              batch_end
);

  localparam int PAW = $clog2(MAX_INDIVIDUALS);
  localparam int CAW = $clog2(MAX_INDIVIDUALS + 1);
  localparam int EAW = $clog2(MAX_ENTRIES);

  wr_req_t           wr;
  seq_stat_t         stat;
  logic              accept;
  logic [PAW-1:0]    par_addr_a, par_addr_b;
  logic [PAR_W-1:0]  par_rd_a, par_rd_b;
  logic [CAW-1:0]    col_addr_a, col_addr_b;
  logic [SLOT_W-1:0] col_rd_a, col_rd_b;
  logic [EAW-1:0]    ent_addr;
  logic [IDX_W-1:0]  row_rd;
  logic [VAL_W-1:0]  val_rd;

  // loads and queries are held off while a query is being worked
  assign in_stall = stat.busy;
  assign accept   = in_valid && !in_stall;

  // load request decode
  always_comb begin
    wr.par_we   = accept && (opcode == OP_LOAD_PARENT);
    wr.col_we   = accept && (opcode == OP_LOAD_COLUMN);
    wr.ent_we   = accept && (opcode == OP_LOAD_ENTRY);
    wr.slot     = slot;
    wr.par_data = {sire_known, sire_index, dam_known, dam_index};
    wr.col_data = column_start;
    wr.row_data = entry_row;
    wr.val_data = entry_value;
  end

  dcp_store #(
    .MAX_INDIVIDUALS(MAX_INDIVIDUALS),
    .MAX_ENTRIES    (MAX_ENTRIES)
  ) u_store (
    .clk       (clk),
    .wr        (wr),
    .par_addr_a(par_addr_a),
    .par_addr_b(par_addr_b),
    .par_rd_a  (par_rd_a),
    .par_rd_b  (par_rd_b),
    .col_addr_a(col_addr_a),
    .col_addr_b(col_addr_b),
    .col_rd_a  (col_rd_a),
    .col_rd_b  (col_rd_b),
    .ent_addr  (ent_addr),
    .row_rd    (row_rd),
    .val_rd    (val_rd)
  );

  dcp_seq #(
    .MAX_INDIVIDUALS(MAX_INDIVIDUALS),
    .MAX_ENTRIES    (MAX_ENTRIES)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .start            (accept && (opcode == OP_QUERY)),
    .first_individual (first_individual),
    .second_individual(second_individual),
    .last_pair        (last_pair),
    .par_addr_a       (par_addr_a),
    .par_addr_b       (par_addr_b),
    .par_rd_a         (par_rd_a),
    .par_rd_b         (par_rd_b),
    .col_addr_a       (col_addr_a),
    .col_addr_b       (col_addr_b),
    .col_rd_a         (col_rd_a),
    .col_rd_b         (col_rd_b),
    .ent_addr         (ent_addr),
    .row_rd           (row_rd),
    .val_rd           (val_rd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .coefficient      (coefficient),
    .written          (written),
    .batch_end        (batch_end)
  );

  // a result not written carries a zero coefficient
  a_zero_when_unwritten: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !written) |-> (coefficient == '0))
    else $error("unwritten result with nonzero coefficient");

  // a fresh result only leaves the final state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stat.state == ST_DONE))
    else $error("result raised outside final state");

  // a query never starts while the sequencer is busy
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (stat.state != ST_IDLE) |-> in_stall)
    else $error("request taken during a query");

endmodule
